### sv/mtbd_pkg.sv
`default_nettype none
package mtbd_pkg;

	// Parser phase, one-hot
	typedef enum logic [2:0] {
		PH_STATUS = 3'b001,
		PH_DATA1  = 3'b010,
		PH_DATA2  = 3'b100
	} phase_t;

	typedef enum logic [1:0] {
		EV_NOTE_ON  = 2'd0,
		EV_NOTE_OFF = 2'd1,
		EV_PARAM    = 2'd2
	} event_kind_t;

	// Status high nibbles
	localparam logic [3:0] MSG_NOTE_OFF = 4'h8;
	localparam logic [3:0] MSG_NOTE_ON  = 4'h9;
	localparam logic [3:0] MSG_CTRL     = 4'hB;

	localparam logic [6:0] HELD_NOTE_RST = 7'd60;
	localparam logic [6:0] HELD_VEL_RST  = 7'd100;

	typedef struct packed {
		logic        valid;
		event_kind_t kind;
		logic [6:0]  note;
		logic [6:0]  velocity;
		logic [4:0]  pid;
		logic [6:0]  pval;
	} result_t;

	typedef struct packed {
		logic       hit;
		logic [4:0] id;
	} cc_entry_t;

	// Controller number to parameter index, ascending controller order
	function automatic cc_entry_t cc_lookup(input logic [6:0] cc);
		cc_entry_t e;
		e.hit = 1'b1;
		case (cc)
			7'd14:   e.id = 5'd0;
			7'd16:   e.id = 5'd1;
			7'd18:   e.id = 5'd2;
			7'd19:   e.id = 5'd3;
			7'd20:   e.id = 5'd4;
			7'd21:   e.id = 5'd5;
			7'd22:   e.id = 5'd6;
			7'd24:   e.id = 5'd7;
			7'd25:   e.id = 5'd8;
			7'd26:   e.id = 5'd9;
			7'd28:   e.id = 5'd10;
			7'd30:   e.id = 5'd11;
			7'd31:   e.id = 5'd12;
			7'd32:   e.id = 5'd13;
			7'd33:   e.id = 5'd14;
			7'd34:   e.id = 5'd15;
			7'd35:   e.id = 5'd16;
			7'd36:   e.id = 5'd17;
			7'd37:   e.id = 5'd18;
			7'd38:   e.id = 5'd19;
			7'd39:   e.id = 5'd20;
			7'd40:   e.id = 5'd21;
			7'd71:   e.id = 5'd22;
			7'd72:   e.id = 5'd23;
			7'd74:   e.id = 5'd24;
			7'd75:   e.id = 5'd25;
			7'd77:   e.id = 5'd26;
			7'd104:  e.id = 5'd27;
			7'd109:  e.id = 5'd28;
			7'd110:  e.id = 5'd29;
			7'd127:  e.id = 5'd30;
			default: begin
				e.hit = 1'b0;
				e.id  = 5'd0;
			end
		endcase
		return e;
	endfunction

endpackage
`default_nettype wire

### sv/midi_three_byte_event_decoder.sv
// A byte is parsed out of the input register into the result register.
// Throughput: one byte per cycle; the input register and result register
// advance together whenever the result register is empty or being taken.
// Reset (arst_n low, asynchronous): pipeline empty, parser waits for status,
// gate off, held note 60, held velocity 100.
`default_nettype none
module midi_three_byte_event_decoder
	import mtbd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       rx_valid,
	output logic            rx_stall,
	input  wire logic [7:0] rx_byte,
	output logic            ev_valid,
	input  wire logic       ev_stall,
	output logic [1:0]      event_kind,
	output logic [6:0]      note_number,
	output logic [6:0]      note_velocity,
	output logic [4:0]      param_id,
	output logic [6:0]      param_value
);

	logic       v_s1;
	logic [7:0] byte_s1;
	logic       advance;
	logic       ev_valid_q;
	result_t    res;
	result_t    res_q;

	assign advance  = !ev_valid_q || !ev_stall;
	assign rx_stall = v_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!rx_stall) begin
			v_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!rx_stall && rx_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	mtbd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (v_s1 && advance),
		.byte_in (byte_s1),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_valid_q <= 1'b0;
		end else if (advance) begin
			ev_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			res_q <= res;
		end
	end

	assign ev_valid      = ev_valid_q;
	assign event_kind    = res_q.kind;
	assign note_number   = res_q.note;
	assign note_velocity = res_q.velocity;
	assign param_id      = res_q.pid;
	assign param_value   = res_q.pval;

endmodule
`default_nettype wire

### sv/mtbd_parser.sv
`default_nettype none
module mtbd_parser
	import mtbd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       fire,
	input  wire logic [7:0] byte_in,
	output result_t         res
);

	phase_t     phase_q, phase_d;
	logic [7:0] status_q, status_d;
	logic [6:0] first_q, first_d;
	logic       gate_q, gate_d;
	logic [6:0] note_q, note_d;
	logic [6:0] vel_q, vel_d;
	cc_entry_t  cc;

	assign cc = cc_lookup(first_q);

	always_comb begin
		phase_d  = phase_q;
		status_d = status_q;
		first_d  = first_q;
		gate_d   = gate_q;
		note_d   = note_q;
		vel_d    = vel_q;
		res      = '0;
		if (byte_in[7]) begin
			// status byte always restarts the message
			status_d = byte_in;
			phase_d  = PH_DATA1;
		end else begin
			case (phase_q)
				PH_DATA1: begin
					first_d = byte_in[6:0];
					phase_d = PH_DATA2;
				end
				PH_DATA2: begin
					phase_d = PH_STATUS;
					case (status_q[7:4])
						MSG_NOTE_ON: begin
							if (!gate_q) begin
								gate_d       = 1'b1;
								note_d       = first_q;
								vel_d        = byte_in[6:0];
								res.valid    = 1'b1;
								res.kind     = EV_NOTE_ON;
								res.note     = first_q;
								res.velocity = byte_in[6:0];
							end
						end
						MSG_NOTE_OFF: begin
							if (gate_q) begin
								gate_d       = 1'b0;
								res.valid    = 1'b1;
								res.kind     = EV_NOTE_OFF;
								res.note     = note_q;
								res.velocity = vel_q;
							end
						end
						MSG_CTRL: begin
							if (cc.hit) begin
								res.valid = 1'b1;
								res.kind  = EV_PARAM;
								res.pid   = cc.id;
								res.pval  = byte_in[6:0];
							end
						end
						default: ;
					endcase
				end
				default: phase_d = PH_STATUS;
			endcase
		end
		if (!fire) begin
			res.valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_STATUS;
			status_q <= '0;
			first_q  <= '0;
			gate_q   <= 1'b0;
			note_q   <= HELD_NOTE_RST;
			vel_q    <= HELD_VEL_RST;
		end else if (fire) begin
			phase_q  <= phase_d;
			status_q <= status_d;
			first_q  <= first_d;
			gate_q   <= gate_d;
			note_q   <= note_d;
			vel_q    <= vel_d;
		end
	end

endmodule
`default_nettype wire

### dv/midi_three_byte_event_decoder_test.sv
`default_nettype none
module midi_three_byte_event_decoder_test;
	import mtbd_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_ITEMS = 450;
	localparam int CALM_TAIL    = 60;
	localparam int DRAIN_CYCLES = 8;

	typedef struct {
		event_kind_t kind;
		logic [6:0]  note;
		logic [6:0]  vel;
		logic [4:0]  pid;
		logic [6:0]  pval;
	} midi_event_t;

	// typed rows carry their own expectation; others go through the predictor
	typedef struct {
		logic [7:0]  data;
		bit          typed;
		bit          has_ev;
		midi_event_t ev;
	} stim_row_t;

	logic       clk;
	logic       arst_n;
	logic       rx_valid;
	logic       rx_stall;
	logic [7:0] rx_byte;
	logic       ev_valid;
	logic       ev_stall;
	logic [1:0] event_kind;
	logic [6:0] note_number;
	logic [6:0] note_velocity;
	logic [4:0] param_id;
	logic [6:0] param_value;

	midi_three_byte_event_decoder u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.rx_valid     (rx_valid),
		.rx_stall     (rx_stall),
		.rx_byte      (rx_byte),
		.ev_valid     (ev_valid),
		.ev_stall     (ev_stall),
		.event_kind   (event_kind),
		.note_number  (note_number),
		.note_velocity(note_velocity),
		.param_id     (param_id),
		.param_value  (param_value)
	);

	// parser mirror
	phase_t     ph;
	logic [7:0] stat_byte;
	logic [6:0] data1_byte;
	bit         gate;
	logic [6:0] note_keep;
	logic [6:0] vel_keep;

	logic [6:0] cc_list [31];
	int         cc_slot [128];

	stim_row_t   stim_rows [$];
	midi_event_t expected_events [$];
	midi_event_t want;
	int          errors;
	int          cycle_count;
	bit          calm;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit predict_event(input logic [7:0] b, output midi_event_t ev);
		bit hit;
		int slot;
		hit = 1'b0;
		ev.kind = EV_NOTE_ON;
		ev.note = '0;
		ev.vel  = '0;
		ev.pid  = '0;
		ev.pval = '0;
		if (b[7]) begin
			// any status restarts the message, mid-message or not
			stat_byte = b;
			ph = PH_DATA1;
		end else begin
			case (ph)
				PH_DATA1: begin
					data1_byte = b[6:0];
					ph = PH_DATA2;
				end
				PH_DATA2: begin
					ph = PH_STATUS;
					case (stat_byte[7:4])
						MSG_NOTE_ON: begin
							if (!gate) begin
								note_keep = data1_byte;
								vel_keep  = b[6:0];
								gate      = 1'b1;
								ev.kind   = EV_NOTE_ON;
								ev.note   = note_keep;
								ev.vel    = vel_keep;
								hit       = 1'b1;
							end
						end
						MSG_NOTE_OFF: begin
							if (gate) begin
								gate    = 1'b0;
								ev.kind = EV_NOTE_OFF;
								ev.note = note_keep;
								ev.vel  = vel_keep;
								hit     = 1'b1;
							end
						end
						MSG_CTRL: begin
							slot = cc_slot[data1_byte];
							if (slot >= 0) begin
								ev.kind = EV_PARAM;
								ev.pid  = slot[4:0];
								ev.pval = b[6:0];
								hit     = 1'b1;
							end
						end
						default: ;
					endcase
				end
				default: ph = PH_STATUS; // stray data, no running status
			endcase
		end
		return hit;
	endfunction

	function automatic void add_row(input logic [7:0] b, input bit typed);
		stim_row_t r;
		r.data    = b;
		r.typed   = typed;
		r.has_ev  = 1'b0;
		r.ev.kind = EV_NOTE_ON;
		r.ev.note = '0;
		r.ev.vel  = '0;
		r.ev.pid  = '0;
		r.ev.pval = '0;
		stim_rows.push_back(r);
	endfunction

	function automatic void add_event_row(input logic [7:0] b, input event_kind_t k,
			input logic [6:0] n, input logic [6:0] v, input logic [4:0] p,
			input logic [6:0] pv);
		stim_row_t r;
		r.data    = b;
		r.typed   = 1'b1;
		r.has_ev  = 1'b1;
		r.ev.kind = k;
		r.ev.note = n;
		r.ev.vel  = v;
		r.ev.pid  = p;
		r.ev.pval = pv;
		stim_rows.push_back(r);
	endfunction

	function automatic logic [7:0] rand_data();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel == 0)
			return 8'h00;
		if (sel == 1)
			return 8'h7F;
		return 8'($urandom_range(0, 127));
	endfunction

	function automatic void add_random_message();
		int sel;
		int n;
		logic [7:0] ch;
		logic [7:0] st;
		sel = $urandom_range(0, 99);
		ch  = 8'($urandom_range(0, 15));
		if (sel < 30) begin
			add_row(8'h90 | ch, 1'b0);
			add_row(rand_data(), 1'b0);
			add_row(rand_data(), 1'b0);
		end else if (sel < 55) begin
			add_row(8'h80 | ch, 1'b0);
			add_row(rand_data(), 1'b0);
			add_row(rand_data(), 1'b0);
		end else if (sel < 80) begin
			add_row(8'hB0 | ch, 1'b0);
			if ($urandom_range(0, 3) != 0)
				add_row({1'b0, cc_list[$urandom_range(0, 30)]}, 1'b0);
			else
				add_row(rand_data(), 1'b0);
			add_row(rand_data(), 1'b0);
		end else if (sel < 87) begin
			// statuses that decode to nothing, system and real-time included
			case ($urandom_range(0, 4))
				0: st = 8'hA0 | ch;
				1: st = 8'hC0 | ch;
				2: st = 8'hD0 | ch;
				3: st = 8'hE0 | ch;
				default: st = 8'hF0 | ch;
			endcase
			add_row(st, 1'b0);
			n = $urandom_range(0, 2);
			repeat (n) add_row(rand_data(), 1'b0);
		end else if (sel < 93) begin
			n = $urandom_range(1, 3);
			repeat (n) add_row(rand_data(), 1'b0);
		end else begin
			// broken message: any status with at most one data byte after it
			add_row(8'h80 | 8'($urandom_range(0, 127)), 1'b0);
			n = $urandom_range(0, 1);
			repeat (n) add_row(rand_data(), 1'b0);
		end
	endfunction

	task automatic send_row(input stim_row_t r);
		midi_event_t ev;
		bit hit;
		if (!calm && $urandom_range(0, 7) == 0) begin
			rx_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte  <= r.data;
		forever begin
			@(posedge clk);
			if (!rx_stall)
				break;
		end
		hit = predict_event(r.data, ev);
		if (r.typed) begin
			if (r.has_ev)
				expected_events.push_back(r.ev);
		end else if (hit) begin
			expected_events.push_back(ev);
		end
		@(negedge clk);
	endtask

	// output side stall bursts
	initial begin
		ev_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 9) == 0) begin
				ev_stall <= 1'b1;
				repeat ($urandom_range(1, 16)) @(negedge clk);
			end
			ev_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && ev_valid && !ev_stall) begin
			if (expected_events.size() == 0) begin
				$error("event with none expected: kind %0d note %0d vel %0d pid %0d pval %0d",
					event_kind, note_number, note_velocity, param_id, param_value);
				errors++;
			end else begin
				want = expected_events.pop_front();
				if (event_kind !== want.kind) begin
					$error("event_kind: expected %0d, got %0d", want.kind, event_kind);
					errors++;
				end
				if (note_number !== want.note) begin
					$error("note_number: expected %0d, got %0d", want.note, note_number);
					errors++;
				end
				if (note_velocity !== want.vel) begin
					$error("note_velocity: expected %0d, got %0d", want.vel, note_velocity);
					errors++;
				end
				if (param_id !== want.pid) begin
					$error("param_id: expected %0d, got %0d", want.pid, param_id);
					errors++;
				end
				if (param_value !== want.pval) begin
					$error("param_value: expected %0d, got %0d", want.pval, param_value);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[midi_three_byte_event_decoder] ERROR");
			$finish;
		end
	end

	initial begin
		int first_random;
		int total;
		rx_valid    = 1'b0;
		rx_byte     = 8'h00;
		arst_n      = 1'b0;
		errors      = 0;
		cycle_count = 0;
		calm        = 1'b0;

		cc_list = '{7'd14, 7'd16, 7'd18, 7'd19, 7'd20, 7'd21, 7'd22, 7'd24, 7'd25,
			7'd26, 7'd28, 7'd30, 7'd31, 7'd32, 7'd33, 7'd34, 7'd35, 7'd36, 7'd37,
			7'd38, 7'd39, 7'd40, 7'd71, 7'd72, 7'd74, 7'd75, 7'd77, 7'd104, 7'd109,
			7'd110, 7'd127};
		for (int i = 0; i < 128; i++)
			cc_slot[i] = -1;
		for (int i = 0; i < 31; i++)
			cc_slot[cc_list[i]] = i;

		ph         = PH_STATUS;
		stat_byte  = 8'h00;
		data1_byte = 7'd0;
		gate       = 1'b0;
		note_keep  = HELD_NOTE_RST;
		vel_keep   = HELD_VEL_RST;

		// data with no status before it is dropped
		add_row(8'h7F, 1'b1);
		// note-on, top note, zero velocity, channel bits set
		add_row(8'h9F, 1'b1);
		add_row(8'h7F, 1'b1);
		add_event_row(8'h00, EV_NOTE_ON, 7'd127, 7'd0, 5'd0, 7'd0);
		// second note-on while the gate is held is dropped
		add_row(8'h90, 1'b1);
		add_row(8'h01, 1'b1);
		add_row(8'h02, 1'b1);
		// note-off reports the held note, not its own data
		add_row(8'h8A, 1'b1);
		add_row(8'h11, 1'b1);
		add_event_row(8'h22, EV_NOTE_OFF, 7'd127, 7'd0, 5'd0, 7'd0);
		// lowest and highest mapped controllers
		add_row(8'hB0, 1'b1);
		add_row(8'h0E, 1'b1);
		add_event_row(8'h00, EV_PARAM, 7'd0, 7'd0, 5'd0, 7'd0);
		add_row(8'hBF, 1'b1);
		add_row(8'h7F, 1'b1);
		add_event_row(8'h7F, EV_PARAM, 7'd0, 7'd0, 5'd30, 7'd127);
		// unmapped controller
		add_row(8'hB3, 1'b1);
		add_row(8'h00, 1'b1);
		add_row(8'h55, 1'b1);
		// real-time status cuts a note-on short, then decodes to nothing
		add_row(8'h90, 1'b0);
		add_row(8'h05, 1'b0);
		add_row(8'hF8, 1'b0);
		add_row(8'h12, 1'b0);
		add_row(8'h34, 1'b0);

		first_random = stim_rows.size();
		while (stim_rows.size() - first_random < RANDOM_ITEMS)
			add_random_message();
		total = stim_rows.size();

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < total; i++) begin
			if (i >= total - CALM_TAIL)
				calm = 1'b1;
			send_row(stim_rows[i]);
		end
		rx_valid <= 1'b0;

		while (expected_events.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0) begin
			$display("[midi_three_byte_event_decoder] OK");
		end else begin
			$display("[midi_three_byte_event_decoder] ERROR");
		end
		$finish;
	end

endmodule
`default_nettype wire
